// ----- rtl/reu_pkg.sv -----
// reu_pkg: action codes, result record and the leading-ones counter for the execute unit
// no dependencies

package reu_pkg;

    localparam logic [3:0] ACT_J      = 4'd0;
    localparam logic [3:0] ACT_CLS    = 4'd1;
    localparam logic [3:0] ACT_BEQ    = 4'd2;
    localparam logic [3:0] ACT_OR     = 4'd3;
    localparam logic [3:0] ACT_RORI   = 4'd4;
    localparam logic [3:0] ACT_SELC   = 4'd5;
    localparam logic [3:0] ACT_LDP    = 4'd6;
    localparam logic [3:0] ACT_LD     = 4'd7;
    localparam logic [3:0] ACT_SLTI   = 4'd8;
    localparam logic [3:0] ACT_ST     = 4'd9;
    localparam logic [3:0] ACT_BNE    = 4'd10;
    localparam logic [3:0] ACT_ADD    = 4'd11;
    localparam logic [3:0] ACT_SETPC  = 4'd12;
    localparam logic [3:0] ACT_SETREG = 4'd13;
    localparam logic [3:0] ACT_SETMEM = 4'd14;

    localparam logic [31:0] PC_KEEP_MASK = 32'hF000_0000;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  reg_writes;
        logic [4:0]  first_reg;
        logic [31:0] first_value;
        logic [4:0]  second_reg;
        logic [31:0] second_value;
        logic        mem_written;
        logic [11:0] mem_address;
        logic [31:0] mem_value;
    } t_result;

    // binary search for the first zero from the top, five levels
    function automatic logic [5:0] count_lead_ones(input logic [31:0] v);
        logic [31:0] x;
        logic [5:0]  n;
        x = v;
        n = 6'd0;
        if (&v) begin
            n = 6'd32;
        end else begin
            if (&x[31:16]) begin n = n + 6'd16; x = x << 16; end
            if (&x[31:24]) begin n = n + 6'd8;  x = x << 8;  end
            if (&x[31:28]) begin n = n + 6'd4;  x = x << 4;  end
            if (&x[31:30]) begin n = n + 6'd2;  x = x << 2;  end
            if (x[31])     begin n = n + 6'd1;               end
        end
        return n;
    endfunction

endpackage

// ----- rtl/reu_ram.sv -----
// reu_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies

module reu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/risc_execute_unit_core.sv -----
// risc_execute_unit_core: executes one instruction or load action per beat against pc,
// register file and byte data memory; uses reu_pkg and reu_ram
//
//   channel | direction | handshake                   | payload
//   in      | in        | i_in_valid / o_in_stall     | action, instr_word, load_target, load_value
//   out     | out       | o_out_valid / i_out_stall   | next_pc .. mem_value
//
// one item at a time: EXEC, DONE for most actions; EXEC, MEM1, DONE for LD;
// EXEC, MEM1, MEM2, DONE, WB2 for LDP (two word reads and two register writes in sequence)
// reset runs a clearing pass over all DATA_BYTES/4 rows of the data memory lanes
// the result waits in an output register; a stalled output holds only the write-back step
// DATA_BYTES must be a power of two

module risc_execute_unit_core #(
    parameter int DATA_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_action,
    input  logic [31:0] i_instr_word,
    input  logic [11:0] i_load_target,
    input  logic [31:0] i_load_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_next_pc,
    output logic [1:0]  o_reg_writes,
    output logic [4:0]  o_first_reg,
    output logic [31:0] o_first_value,
    output logic [4:0]  o_second_reg,
    output logic [31:0] o_second_value,
    output logic        o_mem_written,
    output logic [11:0] o_mem_address,
    output logic [31:0] o_mem_value
);
    import reu_pkg::*;

    localparam int AW   = $clog2(DATA_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = DATA_BYTES / 4;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_MEM1  = 3'd3;
    localparam logic [2:0] ST_MEM2  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;
    localparam logic [2:0] ST_WB2   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [RW-1:0] r_clr;
    logic [31:0]   r_pc;
    logic [3:0]    r_act;
    logic [31:0]   r_w;
    logic [11:0]   r_tgt;
    logic [31:0]   r_lval;
    logic [31:0]   r_rvalid;
    logic          r_va, r_vb;
    logic [AW-1:0] r_maddr;
    t_result       r_res, r_out;
    logic          r_out_valid;

    logic          in_acc, out_free, commit;
    logic [4:0]    ra_addr, rb_addr;
    logic [31:0]   rf_da, rf_db, opa, opb;
    logic          rf_we;
    logic [4:0]    rf_waddr;
    logic [31:0]   rf_wdata;

    logic          mem_we;
    logic [AW-1:0] mem_wbase, mem_rbase;
    logic [31:0]   mem_wdata, mem_word;
    logic [7:0]    lane_q [4];

    t_result       res_e;
    logic [31:0]   pc_e, ld_addr, ldp_addr, br_off, imm_sx, diff;

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == ST_DONE) && out_free;

    assign ra_addr = (i_action == ACT_SELC) ? i_instr_word[15:11] : i_instr_word[25:21];
    assign rb_addr = i_instr_word[20:16];

    // two copies of the register file give two read ports
    reu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(ra_addr), .o_rdata(rf_da)
    );
    reu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(rb_addr), .o_rdata(rf_db)
    );

    assign opa = r_va ? rf_da : 32'd0;
    assign opb = r_vb ? rf_db : 32'd0;

    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = r_res.first_reg;
        rf_wdata = r_res.first_value;
        if (commit) begin
            rf_we = (r_res.reg_writes != 2'd0);
        end else if (r_state == ST_WB2) begin
            rf_we    = 1'b1;
            rf_waddr = r_res.second_reg;
            rf_wdata = r_res.second_value;
        end
    end

    // execute stage
    assign imm_sx   = {{16{r_w[15]}}, r_w[15:0]};
    assign br_off   = {{14{r_w[15]}}, r_w[15:0], 2'b00};
    assign ld_addr  = opa + imm_sx;
    assign ldp_addr = opa + {{19{r_w[10]}}, r_w[10:0], 2'b00};
    assign diff     = opb - opa;

    always_comb begin
        res_e     = '0;
        pc_e      = r_pc;
        mem_we    = 1'b0;
        mem_wbase = ld_addr[AW-1:0];
        mem_wdata = opb;
        case (r_act)
            ACT_J: begin
                pc_e = (r_pc & PC_KEEP_MASK) | {4'b0000, r_w[25:0], 2'b00};
            end
            ACT_CLS: begin
                res_e.reg_writes  = 2'd1;
                res_e.first_reg   = r_w[25:21];
                res_e.first_value = {26'd0, count_lead_ones(opb)};
            end
            ACT_BEQ: begin
                if (opa == opb) pc_e = r_pc + br_off;
            end
            ACT_BNE: begin
                if (opa != opb) pc_e = r_pc + br_off;
            end
            ACT_OR: begin
                res_e.reg_writes  = 2'd1;
                res_e.first_reg   = r_w[15:11];
                res_e.first_value = opa | opb;
            end
            ACT_ADD: begin
                res_e.reg_writes  = 2'd1;
                res_e.first_reg   = r_w[15:11];
                res_e.first_value = opa + opb;
            end
            ACT_RORI: begin
                res_e.reg_writes  = 2'd1;
                res_e.first_reg   = r_w[25:21];
                res_e.first_value = 32'({opb, opb} >> r_w[15:11]);
            end
            ACT_SELC: begin
                // a comes from port b, b from port a
                res_e.reg_writes  = 2'd1;
                res_e.first_reg   = r_w[25:21];
                res_e.first_value = diff[31] ? opa : opb;
            end
            ACT_LDP: begin
                res_e.reg_writes = 2'd2;
                res_e.first_reg  = r_w[20:16];
                res_e.second_reg = r_w[15:11];
            end
            ACT_LD: begin
                res_e.reg_writes = 2'd1;
                res_e.first_reg  = r_w[20:16];
            end
            ACT_SLTI: begin
                res_e.reg_writes  = 2'd1;
                res_e.first_reg   = r_w[20:16];
                res_e.first_value = ($signed(opa) < $signed(imm_sx)) ? 32'd1 : 32'd0;
            end
            ACT_ST: begin
                mem_we            = 1'b1;
                res_e.mem_written = 1'b1;
                res_e.mem_address = 12'(32'(ld_addr[AW-1:0]));
                res_e.mem_value   = opb;
            end
            ACT_SETPC: begin
                pc_e = r_lval;
            end
            ACT_SETREG: begin
                res_e.reg_writes  = 2'd1;
                res_e.first_reg   = r_tgt[4:0];
                res_e.first_value = r_lval;
            end
            ACT_SETMEM: begin
                mem_we            = 1'b1;
                mem_wbase         = AW'(32'(r_tgt));
                mem_wdata         = r_lval;
                res_e.mem_written = 1'b1;
                res_e.mem_address = 12'(32'(mem_wbase));
                res_e.mem_value   = r_lval;
            end
            default: begin
            end
        endcase
        res_e.next_pc = pc_e;
    end

    always_comb begin
        case (r_state)
            ST_EXEC: mem_rbase = (r_act == ACT_LDP) ? ldp_addr[AW-1:0] : ld_addr[AW-1:0];
            ST_MEM1: mem_rbase = r_maddr + AW'(3'd4);
            default: mem_rbase = r_maddr;
        endcase
    end

    // four byte lanes; an unaligned word touches each lane once
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [1:0]    wsel, rsel;
        logic [AW-1:0] wa, ra;
        logic [RW-1:0] lwaddr;
        logic [7:0]    lwdata;
        logic          lwe;

        assign wsel   = 2'(l) - mem_wbase[1:0];
        assign rsel   = 2'(l) - mem_rbase[1:0];
        assign wa     = mem_wbase + AW'(wsel);
        assign ra     = mem_rbase + AW'(rsel);
        assign lwe    = (r_state == ST_CLEAR) || ((r_state == ST_EXEC) && mem_we);
        assign lwaddr = (r_state == ST_CLEAR) ? r_clr : wa[AW-1:2];
        assign lwdata = (r_state == ST_CLEAR) ? 8'd0 : mem_wdata[8*wsel +: 8];

        reu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
            .i_clk(i_clk), .i_we(lwe), .i_waddr(lwaddr), .i_wdata(lwdata),
            .i_raddr(ra[AW-1:2]), .o_rdata(lane_q[l])
        );
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mem_word[8*i +: 8] = lane_q[2'(r_maddr[1:0] + 2'(i))];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == RW'(ROWS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (in_acc) n_state = ST_EXEC;
            ST_EXEC:  n_state = (r_act == ACT_LD || r_act == ACT_LDP) ? ST_MEM1 : ST_DONE;
            ST_MEM1:  n_state = (r_act == ACT_LDP) ? ST_MEM2 : ST_DONE;
            ST_MEM2:  n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = (r_res.reg_writes == 2'd2) ? ST_WB2 : ST_IDLE;
            ST_WB2:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_pc        <= 32'd0;
            r_rvalid    <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + RW'(1);
            if (rf_we) r_rvalid[rf_waddr] <= 1'b1;
            if (r_state == ST_EXEC) r_pc <= pc_e;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act  <= i_action;
            r_w    <= i_instr_word;
            r_tgt  <= i_load_target;
            r_lval <= i_load_value;
            r_va   <= r_rvalid[ra_addr];
            r_vb   <= r_rvalid[rb_addr];
        end
        if (r_state == ST_EXEC) begin
            r_res   <= res_e;
            r_maddr <= mem_rbase;
        end
        if (r_state == ST_MEM1) r_res.first_value  <= mem_word;
        if (r_state == ST_MEM2) r_res.second_value <= mem_word;
        if (commit) r_out <= r_res;
    end

    assign o_out_valid    = r_out_valid;
    assign o_next_pc      = r_out.next_pc;
    assign o_reg_writes   = r_out.reg_writes;
    assign o_first_reg    = r_out.first_reg;
    assign o_first_value  = r_out.first_value;
    assign o_second_reg   = r_out.second_reg;
    assign o_second_value = r_out.second_value;
    assign o_mem_written  = r_out.mem_written;
    assign o_mem_address  = r_out.mem_address;
    assign o_mem_value    = r_out.mem_value;

    a_acc_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ST_EXEC) else $error("accepted beat did not start execute");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside write-back");

    a_no_mixed_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_mem_written && (o_reg_writes != 2'd0)))
        else $error("result reports both register and memory writes");

    a_wb2_only_ldp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB2) |-> (r_act == ACT_LDP))
        else $error("second register write outside LDP");

endmodule
